[rtl/core/scb_pkg.sv]
// Shared types, constants and helpers of the spectral column binning unit.
package scb_pkg;

    localparam int MAX_COLUMNS_D   = 1024;
    localparam int MAX_ROWS_D      = 128;
    localparam int PIXEL_BITS_D    = 16;
    localparam int FRACTION_BITS_D = 8;
    localparam int CFG_DATA_W      = 11;
    localparam int CFG_ADDR_W      = 3;
    localparam int QUEUE_DEPTH     = 4;

    typedef enum logic [CFG_ADDR_W-1:0] {
        CFG_COLUMNS       = 3'd0,
        CFG_ROWS          = 3'd1,
        CFG_START_ROW     = 3'd2,
        CFG_END_ROW       = 3'd3,
        CFG_MEAN_ENABLE   = 3'd4,
        CFG_SUBTRACT_DARK = 3'd5,
        CFG_DARK_CAPTURE  = 3'd6
    } t_cfg_idx;

    typedef struct packed {
        logic [10:0] columns;
        logic [7:0]  rows;
        logic [6:0]  start_row;
        logic [7:0]  end_row;
        logic        mean_enable;
        logic        subtract_dark;
        logic        dark_capture;
    } t_cfg;

    typedef struct packed {
        logic [15:0] pixel;
        logic        frame_start;
    } t_in_word;

    typedef struct packed {
        logic [9:0]         column_index;
        logic signed [31:0] column_value;
        logic               is_last;
        logic signed [31:0] min_value;
        logic signed [31:0] max_value;
        logic               dark_saved;
    } t_out_word;

    typedef struct packed {
        logic sel;
        logic first_pix;
        logic first_row;
        logic last_row;
        logic last_col;
    } t_job_ctl;

    function automatic int clamp_i(int v, int lo, int hi);
        int r;
        r = v;
        if (v < lo) r = lo;
        if (v > hi) r = hi;
        return r;
    endfunction

endpackage

[rtl/core/scb_ram.sv]
// Generic single-write, single-read RAM with registered read data.
module scb_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 1024,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;
endmodule

[rtl/core/scb_fifo.sv]
// Short register queue between the classifier and the accumulator.
module scb_fifo #(
    parameter int WIDTH = 8,
    parameter int DEPTH = scb_pkg::QUEUE_DEPTH,
    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1,
    localparam int CW = $clog2(DEPTH + 1)
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    input  logic [WIDTH-1:0] i_data,
    input  logic             i_pop,
    output logic [WIDTH-1:0] o_data,
    output logic             o_full,
    output logic             o_empty
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [PW-1:0]    r_wr, r_rd;
    logic [CW-1:0]    r_cnt;
    logic             w_push, w_pop;

    assign o_full  = (r_cnt == CW'(DEPTH));
    assign o_empty = (r_cnt == '0);
    assign w_push  = i_push && !o_full;
    assign w_pop   = i_pop && !o_empty;
    assign o_data  = r_mem[r_rd];

    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_mem[r_wr] <= i_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            if (w_push) begin
                r_wr <= (r_wr == PW'(DEPTH - 1)) ? '0 : r_wr + PW'(1);
            end
            if (w_pop) begin
                r_rd <= (r_rd == PW'(DEPTH - 1)) ? '0 : r_rd + PW'(1);
            end
            if (w_push && !w_pop) begin
                r_cnt <= r_cnt + CW'(1);
            end else if (w_pop && !w_push) begin
                r_cnt <= r_cnt - CW'(1);
            end
        end
    end
endmodule

[rtl/core/scb_front.sv]
// Position tracking and classification of incoming pixel words.
module scb_front #(
    parameter int MAX_COLUMNS = scb_pkg::MAX_COLUMNS_D,
    parameter int MAX_ROWS    = scb_pkg::MAX_ROWS_D,
    parameter int PIXEL_BITS  = scb_pkg::PIXEL_BITS_D,
    localparam int COL_W = (MAX_COLUMNS > 1) ? $clog2(MAX_COLUMNS) : 1,
    localparam int ROW_W = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  scb_pkg::t_cfg         i_cfg,
    input  logic                  i_push,
    input  scb_pkg::t_in_word     i_word,
    input  logic                  i_q_full,
    output logic                  o_full,
    output logic                  o_q_push,
    output scb_pkg::t_job_ctl     o_q_ctl,
    output logic [PIXEL_BITS-1:0] o_q_pixel,
    output logic [ROW_W-1:0]      o_q_row,
    output logic [COL_W-1:0]      o_q_col
);
    logic [ROW_W-1:0] r_row, n_row;
    logic [COL_W-1:0] r_col, n_col;
    logic [ROW_W-1:0] w_row;
    logic [COL_W-1:0] w_col;
    int               w_cols, w_rows, w_endr, w_start;
    logic             w_acc;

    assign o_full = i_q_full;
    assign w_acc  = i_push && !i_q_full;

    always_comb begin
        w_cols  = scb_pkg::clamp_i(int'(i_cfg.columns), 1, MAX_COLUMNS);
        w_rows  = scb_pkg::clamp_i(int'(i_cfg.rows), 1, MAX_ROWS);
        w_endr  = (int'(i_cfg.end_row) > w_rows) ? w_rows : int'(i_cfg.end_row);
        w_start = int'(i_cfg.start_row);
        w_row   = i_word.frame_start ? '0 : r_row;
        w_col   = i_word.frame_start ? '0 : r_col;
        if (int'(w_row) >= w_rows) begin
            w_row = '0;
        end
        if (int'(w_col) >= w_cols) begin
            w_col = '0;
        end
        o_q_ctl.sel       = (w_start < w_endr) && (int'(w_row) >= w_start)
                            && (int'(w_row) < w_endr);
        o_q_ctl.first_pix = (w_row == '0) && (w_col == '0);
        o_q_ctl.first_row = (int'(w_row) == w_start);
        o_q_ctl.last_row  = (int'(w_row) == w_endr - 1);
        o_q_ctl.last_col  = (int'(w_col) == w_cols - 1);
        o_q_pixel = PIXEL_BITS'(i_word.pixel);
        o_q_row   = w_row;
        o_q_col   = w_col;
        o_q_push  = w_acc && (o_q_ctl.sel || o_q_ctl.first_pix);
        n_col = w_col + COL_W'(1);
        n_row = w_row;
        if (int'(w_col) + 1 >= w_cols) begin
            n_col = '0;
            n_row = (int'(w_row) + 1 >= w_rows) ? '0 : w_row + ROW_W'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_row <= '0;
            r_col <= '0;
        end else if (w_acc) begin
            r_row <= n_row;
            r_col <= n_col;
        end
    end
endmodule

[rtl/core/scb_back.sv]
// Accumulation, dark handling, mean division and result register.
module scb_back #(
    parameter int MAX_COLUMNS   = scb_pkg::MAX_COLUMNS_D,
    parameter int MAX_ROWS      = scb_pkg::MAX_ROWS_D,
    parameter int PIXEL_BITS    = scb_pkg::PIXEL_BITS_D,
    parameter int FRACTION_BITS = scb_pkg::FRACTION_BITS_D,
    localparam int COL_W  = (MAX_COLUMNS > 1) ? $clog2(MAX_COLUMNS) : 1,
    localparam int ROW_W  = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1,
    localparam int DARK_D = MAX_ROWS * MAX_COLUMNS,
    localparam int DARK_W = (DARK_D > 1) ? $clog2(DARK_D) : 1,
    localparam int RCNT_W = $clog2(MAX_ROWS + 1),
    localparam int SUM_W  = PIXEL_BITS + RCNT_W + 1,
    localparam int SCL_W  = SUM_W + FRACTION_BITS,
    localparam int STEP_W = $clog2(SCL_W + 1)
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  scb_pkg::t_cfg         i_cfg,
    input  logic                  i_q_empty,
    input  scb_pkg::t_job_ctl     i_q_ctl,
    input  logic [PIXEL_BITS-1:0] i_q_pixel,
    input  logic [ROW_W-1:0]      i_q_row,
    input  logic [COL_W-1:0]      i_q_col,
    output logic                  o_q_pop,
    input  logic                  i_pop,
    output logic                  o_empty,
    output scb_pkg::t_out_word    o_word
);
    typedef enum logic [3:0] {
        S_IDLE = 4'b0001,
        S_EXEC = 4'b0010,
        S_DIV  = 4'b0100,
        S_OUT  = 4'b1000
    } t_state;

    t_state                   r_state;
    scb_pkg::t_job_ctl        r_ctl;
    logic [PIXEL_BITS-1:0]    r_pix;
    logic [ROW_W-1:0]         r_row;
    logic [COL_W-1:0]         r_col;
    logic                     r_dark_valid, r_saved, r_neg, r_o_valid;
    logic [SCL_W-1:0]         r_mag;
    logic [RCNT_W-1:0]        r_rem;
    logic [STEP_W-1:0]        r_step;
    logic signed [31:0]       r_val, r_min, r_max;
    scb_pkg::t_out_word       r_out;

    logic [DARK_W-1:0]        w_dark_raddr, w_dark_waddr;
    logic [PIXEL_BITS-1:0]    w_dark_rd;
    logic [SUM_W-1:0]         w_sum_rd;
    logic signed [SUM_W-1:0]  w_contrib, w_sum;
    logic signed [SCL_W-1:0]  w_scl;
    logic                     w_dark_we, w_sum_we;
    logic [RCNT_W:0]          w_rem_sh;
    logic [RCNT_W-1:0]        w_nrows;
    logic                     w_bit;
    logic signed [SCL_W:0]    w_quot;
    logic signed [31:0]       w_nmin, w_nmax;
    logic                     w_load, w_frame_end;

    function automatic logic signed [31:0] sat32(longint v);
        logic signed [31:0] r;
        if (v > 64'sd2147483647) begin
            r = 32'sh7FFFFFFF;
        end else if (v < -64'sd2147483648) begin
            r = 32'sh80000000;
        end else begin
            r = 32'(v);
        end
        return r;
    endfunction

    assign w_dark_raddr = DARK_W'(i_q_row) * DARK_W'(MAX_COLUMNS) + DARK_W'(i_q_col);
    assign w_dark_waddr = DARK_W'(r_row) * DARK_W'(MAX_COLUMNS) + DARK_W'(r_col);
    assign o_q_pop      = (r_state == S_IDLE) && !i_q_empty;
    assign w_nrows      = RCNT_W'(scb_pkg::clamp_i(int'(i_cfg.rows), 1, MAX_ROWS));
    assign w_load       = (r_state == S_OUT) && (!r_o_valid || i_pop);
    assign w_frame_end  = r_ctl.last_row && r_ctl.last_col;

    always_comb begin
        w_contrib = $signed(SUM_W'(r_pix));
        if (i_cfg.subtract_dark && r_dark_valid) begin
            w_contrib = w_contrib - $signed(SUM_W'(w_dark_rd));
        end
        w_sum     = r_ctl.first_row ? w_contrib : $signed(w_sum_rd) + w_contrib;
        w_scl     = $signed(SCL_W'(w_sum)) <<< FRACTION_BITS;
        w_dark_we = (r_state == S_EXEC) && r_ctl.sel && i_cfg.dark_capture;
        w_sum_we  = (r_state == S_EXEC) && r_ctl.sel && !i_cfg.dark_capture;
        w_rem_sh  = {r_rem, r_mag[SCL_W-1]};
        w_bit     = (w_rem_sh >= (RCNT_W+1)'(w_nrows));
        w_quot    = $signed({1'b0, r_mag[SCL_W-2:0], w_bit});
        if (r_neg) begin
            w_quot = -w_quot;
        end
        w_nmin = (r_val < r_min) ? r_val : r_min;
        w_nmax = (r_val > r_max) ? r_val : r_max;
    end

    scb_ram #(.WIDTH(PIXEL_BITS), .DEPTH(DARK_D)) u_dark (
        .i_clk   (i_clk),
        .i_we    (w_dark_we),
        .i_waddr (w_dark_waddr),
        .i_wdata (r_pix),
        .i_raddr (w_dark_raddr),
        .o_rdata (w_dark_rd)
    );

    scb_ram #(.WIDTH(SUM_W), .DEPTH(MAX_COLUMNS)) u_sums (
        .i_clk   (i_clk),
        .i_we    (w_sum_we),
        .i_waddr (r_col),
        .i_wdata (w_sum),
        .i_raddr (i_q_col),
        .o_rdata (w_sum_rd)
    );

    always_ff @(posedge i_clk) begin
        if (o_q_pop) begin
            r_ctl <= i_q_ctl;
            r_pix <= i_q_pixel;
            r_row <= i_q_row;
            r_col <= i_q_col;
        end
        if (r_state == S_EXEC) begin
            r_neg  <= w_scl[SCL_W-1];
            r_mag  <= w_scl[SCL_W-1] ? SCL_W'(-w_scl) : SCL_W'(w_scl);
            r_rem  <= '0;
            r_step <= '0;
            r_val  <= sat32(longint'(w_scl));
        end
        if (r_state == S_DIV) begin
            r_mag  <= {r_mag[SCL_W-2:0], w_bit};
            r_rem  <= w_bit ? RCNT_W'(w_rem_sh - (RCNT_W+1)'(w_nrows)) : RCNT_W'(w_rem_sh);
            r_step <= r_step + STEP_W'(1);
            r_val  <= sat32(longint'(w_quot));
        end
        if (w_load) begin
            r_out.dark_saved   <= r_saved;
            r_out.is_last      <= r_saved || r_ctl.last_col;
            r_out.column_index <= r_saved ? '0 : 10'(r_col);
            r_out.column_value <= r_saved ? '0 : r_val;
            r_out.min_value    <= (!r_saved && r_ctl.last_col) ? w_nmin : '0;
            r_out.max_value    <= (!r_saved && r_ctl.last_col) ? w_nmax : '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_IDLE;
            r_dark_valid <= 1'b0;
            r_saved      <= 1'b0;
            r_o_valid    <= 1'b0;
            r_min        <= 32'sh7FFFFFFF;
            r_max        <= 32'sh80000000;
        end else begin
            if (w_load) begin
                r_o_valid <= 1'b1;
            end else if (i_pop) begin
                r_o_valid <= 1'b0;
            end
            case (r_state)
                S_IDLE: begin
                    if (!i_q_empty) begin
                        r_state <= S_EXEC;
                    end
                end
                S_EXEC: begin
                    if (r_ctl.first_pix) begin
                        r_min <= 32'sh7FFFFFFF;
                        r_max <= 32'sh80000000;
                    end
                    if (r_ctl.sel && i_cfg.dark_capture) begin
                        r_dark_valid <= w_frame_end;
                        r_saved      <= w_frame_end;
                        r_state      <= w_frame_end ? S_OUT : S_IDLE;
                    end else begin
                        r_saved <= 1'b0;
                        if (r_ctl.sel && r_ctl.last_row) begin
                            r_state <= i_cfg.mean_enable ? S_DIV : S_OUT;
                        end else begin
                            r_state <= S_IDLE;
                        end
                    end
                end
                S_DIV: begin
                    if (r_step == STEP_W'(SCL_W - 1)) begin
                        r_state <= S_OUT;
                    end
                end
                S_OUT: begin
                    if (w_load) begin
                        if (!r_saved) begin
                            r_min <= w_nmin;
                            r_max <= w_nmax;
                        end
                        r_state <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign o_empty = !r_o_valid;
    assign o_word  = r_out;
endmodule

[rtl/core/spectral_column_binning_unit.sv]
// Spectral column binning unit: pixel stream in, binned column words out.
// A pixel word passes the queue; the accumulator pops it only when idle and adds it
// to its column sum. After the last row a column result goes to the output register,
// in mean mode first through a divider that makes one quotient bit per cycle. Words
// enter while the queue is not full; a job and its result finish before the next pop.
// Reset: synchronous, active low; clears positions, queue, dark-valid flag.
module spectral_column_binning_unit #(
    parameter int MAX_COLUMNS   = scb_pkg::MAX_COLUMNS_D,
    parameter int MAX_ROWS      = scb_pkg::MAX_ROWS_D,
    parameter int PIXEL_BITS    = scb_pkg::PIXEL_BITS_D,
    parameter int FRACTION_BITS = scb_pkg::FRACTION_BITS_D
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              push,
    output logic                              full,
    input  scb_pkg::t_in_word                 i_word,
    output logic                              empty,
    input  logic                              pop,
    output scb_pkg::t_out_word                o_word,
    input  logic                              i_cfg_we,
    input  logic [scb_pkg::CFG_ADDR_W-1:0]    i_cfg_addr,
    input  logic [scb_pkg::CFG_DATA_W-1:0]    i_cfg_wdata
);
    localparam int COL_W = (MAX_COLUMNS > 1) ? $clog2(MAX_COLUMNS) : 1;
    localparam int ROW_W = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;
    localparam int CTL_W = $bits(scb_pkg::t_job_ctl);
    localparam int JOB_W = CTL_W + PIXEL_BITS + ROW_W + COL_W;

    scb_pkg::t_cfg          r_cfg;
    scb_pkg::t_job_ctl      w_f_ctl, w_b_ctl;
    logic [PIXEL_BITS-1:0]  w_f_pix, w_b_pix;
    logic [ROW_W-1:0]       w_f_row, w_b_row;
    logic [COL_W-1:0]       w_f_col, w_b_col;
    logic [JOB_W-1:0]       w_q_din, w_q_dout;
    logic                   w_q_push, w_q_pop, w_q_full, w_q_empty;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.columns       <= 11'd1024;
            r_cfg.rows          <= 8'd128;
            r_cfg.start_row     <= 7'd0;
            r_cfg.end_row       <= 8'd128;
            r_cfg.mean_enable   <= 1'b1;
            r_cfg.subtract_dark <= 1'b0;
            r_cfg.dark_capture  <= 1'b0;
        end else if (i_cfg_we) begin
            case (scb_pkg::t_cfg_idx'(i_cfg_addr))
                scb_pkg::CFG_COLUMNS:       r_cfg.columns       <= i_cfg_wdata;
                scb_pkg::CFG_ROWS:          r_cfg.rows          <= i_cfg_wdata[7:0];
                scb_pkg::CFG_START_ROW:     r_cfg.start_row     <= i_cfg_wdata[6:0];
                scb_pkg::CFG_END_ROW:       r_cfg.end_row       <= i_cfg_wdata[7:0];
                scb_pkg::CFG_MEAN_ENABLE:   r_cfg.mean_enable   <= i_cfg_wdata[0];
                scb_pkg::CFG_SUBTRACT_DARK: r_cfg.subtract_dark <= i_cfg_wdata[0];
                scb_pkg::CFG_DARK_CAPTURE:  r_cfg.dark_capture  <= i_cfg_wdata[0];
                default: ;
            endcase
        end
    end

    scb_front #(
        .MAX_COLUMNS (MAX_COLUMNS),
        .MAX_ROWS    (MAX_ROWS),
        .PIXEL_BITS  (PIXEL_BITS)
    ) u_front (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_cfg     (r_cfg),
        .i_push    (push),
        .i_word    (i_word),
        .i_q_full  (w_q_full),
        .o_full    (full),
        .o_q_push  (w_q_push),
        .o_q_ctl   (w_f_ctl),
        .o_q_pixel (w_f_pix),
        .o_q_row   (w_f_row),
        .o_q_col   (w_f_col)
    );

    assign w_q_din = {w_f_ctl, w_f_pix, w_f_row, w_f_col};
    assign {w_b_ctl, w_b_pix, w_b_row, w_b_col} = w_q_dout;

    scb_fifo #(.WIDTH(JOB_W)) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_q_push),
        .i_data  (w_q_din),
        .i_pop   (w_q_pop),
        .o_data  (w_q_dout),
        .o_full  (w_q_full),
        .o_empty (w_q_empty)
    );

    scb_back #(
        .MAX_COLUMNS   (MAX_COLUMNS),
        .MAX_ROWS      (MAX_ROWS),
        .PIXEL_BITS    (PIXEL_BITS),
        .FRACTION_BITS (FRACTION_BITS)
    ) u_back (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_cfg     (r_cfg),
        .i_q_empty (w_q_empty),
        .i_q_ctl   (w_b_ctl),
        .i_q_pixel (w_b_pix),
        .i_q_row   (w_b_row),
        .i_q_col   (w_b_col),
        .o_q_pop   (w_q_pop),
        .i_pop     (pop),
        .o_empty   (empty),
        .o_word    (o_word)
    );

`ifndef NO_ASSERTIONS
    a_no_pop_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(w_q_pop && w_q_empty)) else $error("queue popped while empty");
    a_saved_is_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!empty && o_word.dark_saved) |-> (o_word.is_last && o_word.column_value == 0))
        else $error("dark saved word malformed");
    a_push_gated: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_q_push |-> (push && !full)) else $error("queue write without accepted word");
`endif
endmodule
